[hw/rtl/skt_pkg.sv]
`default_nettype none

package skt_pkg;

  localparam int unsigned OP_W         = 3;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned ST_W         = 3;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned SKT_CAPACITY = 64;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 3'd0,
    OP_INS_DUP = 3'd1,
    OP_INS_UNI = 3'd2,
    OP_DELETE  = 3'd3,
    OP_SEARCH  = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_MISSING = 3'd3,
    ST_BADIDX  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND_RD,
    S_FIND_CHK,
    S_INS_RD,
    S_INS_CHK,
    S_DEL_RD,
    S_DEL_WR,
    S_IDX_CHK,
    S_DONE
  } ctrl_state_t;

  // read address source
  typedef enum logic [1:0] {
    RD_MID,
    RD_PTR_DN,
    RD_PTR_UP,
    RD_IDX
  } rd_sel_t;

  // result position source
  typedef enum logic [1:0] {
    POS_ZERO,
    POS_MID,
    POS_PTR,
    POS_IDX
  } pos_sel_t;

  typedef enum logic {
    WR_KEY,
    WR_RDATA
  } wr_src_t;

  typedef struct packed {
    logic     load_req;
    logic     clear_cnt;
    logic     inc_cnt;
    logic     dec_cnt;
    logic     ptr_from_cnt;
    logic     ptr_from_mid;
    logic     ptr_dec;
    logic     ptr_inc;
    logic     lo_up;
    logic     hi_down;
    logic     mid_load;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_src_t  wr_src;
    logic     res_load;
    status_t  res_status;
    pos_sel_t res_pos_sel;
    logic     res_kout_rdata;
    logic     out_load;
  } skt_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic idx_ok;
    logic range_ok;
    logic rd_eq_key;
    logic rd_lt_key;
    logic rd_gt_key;
    logic at_bottom;
    logic del_more;
  } skt_stat_t;

endpackage

`default_nettype wire

[hw/rtl/skt_if.sv]
`default_nettype none

interface skt_req_if;
  import skt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [KEY_W-1:0] key_in;
  logic [IDX_W-1:0]        index_in;

  modport source (output valid, output opcode, output key_in, output index_in, input ready);
  modport sink   (input valid, input opcode, input key_in, input index_in, output ready);
endinterface

interface skt_rsp_if;
  import skt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic [POS_W-1:0]        position;
  logic signed [KEY_W-1:0] key_out;
  logic [CNT_W-1:0]        count;

  modport source (output valid, output status, output position, output key_out, output count,
                  input ready);
  modport sink   (input valid, input status, input position, input key_out, input count,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/skt_ram.sv]
`default_nettype none

module skt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/skt_ctrl.sv]
`default_nettype none

module skt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  skt_pkg::skt_stat_t stat,
  output skt_pkg::skt_cmd_t  cmd
);
  import skt_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r;
  logic        out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_INS_DUP: state_nxt = stat.full ? S_DONE : S_INS_RD;
          OP_INS_UNI: state_nxt = stat.full ? S_DONE : S_FIND_RD;
          OP_DELETE:  state_nxt = S_FIND_RD;
          OP_SEARCH:  state_nxt = S_FIND_RD;
          OP_READ:    state_nxt = stat.idx_ok ? S_IDX_CHK : S_DONE;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_FIND_RD: begin
        if (stat.range_ok) begin
          state_nxt = S_FIND_CHK;
        end else if (stat.op == OP_INS_UNI) begin
          state_nxt = S_INS_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FIND_CHK: begin
        if (stat.rd_eq_key) begin
          state_nxt = (stat.op == OP_DELETE) ? S_DEL_RD : S_DONE;
        end else begin
          state_nxt = S_FIND_RD;
        end
      end
      S_INS_RD:  state_nxt = stat.at_bottom ? S_DONE : S_INS_CHK;
      S_INS_CHK: state_nxt = stat.rd_gt_key ? S_INS_RD : S_DONE;
      S_DEL_RD:  state_nxt = stat.del_more ? S_DEL_WR : S_DONE;
      S_DEL_WR:  state_nxt = S_DEL_RD;
      S_IDX_CHK: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_CLEAR: begin
            cmd.clear_cnt  = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_OK;
          end
          OP_INS_DUP: begin
            if (stat.full) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_FULL;
            end else begin
              cmd.ptr_from_cnt = 1'b1;
            end
          end
          OP_INS_UNI: begin
            if (stat.full) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_FULL;
            end
          end
          OP_DELETE: begin
          end
          OP_SEARCH: begin
          end
          OP_READ: begin
            if (stat.idx_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_IDX;
            end else begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_BADIDX;
            end
          end
          default: begin
            // unused opcode: no change, plain ok
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_OK;
          end
        endcase
      end
      S_FIND_RD: begin
        if (stat.range_ok) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_MID;
          cmd.mid_load = 1'b1;
        end else if (stat.op == OP_INS_UNI) begin
          cmd.ptr_from_cnt = 1'b1;
        end else begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_MISSING;
        end
      end
      S_FIND_CHK: begin
        if (stat.rd_eq_key) begin
          cmd.res_load    = 1'b1;
          cmd.res_pos_sel = POS_MID;
          if (stat.op == OP_INS_UNI) begin
            cmd.res_status = ST_DUP;
          end else begin
            cmd.res_status   = ST_OK;
            cmd.ptr_from_mid = (stat.op == OP_DELETE);
          end
        end else if (stat.rd_lt_key) begin
          cmd.lo_up = 1'b1;
        end else begin
          cmd.hi_down = 1'b1;
        end
      end
      S_INS_RD: begin
        if (stat.at_bottom) begin
          cmd.wr_en       = 1'b1;
          cmd.wr_src      = WR_KEY;
          cmd.inc_cnt     = 1'b1;
          cmd.res_load    = 1'b1;
          cmd.res_status  = ST_OK;
          cmd.res_pos_sel = POS_PTR;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_DN;
        end
      end
      S_INS_CHK: begin
        cmd.wr_en = 1'b1;
        if (stat.rd_gt_key) begin
          cmd.wr_src  = WR_RDATA;
          cmd.ptr_dec = 1'b1;
        end else begin
          cmd.wr_src      = WR_KEY;
          cmd.inc_cnt     = 1'b1;
          cmd.res_load    = 1'b1;
          cmd.res_status  = ST_OK;
          cmd.res_pos_sel = POS_PTR;
        end
      end
      S_DEL_RD: begin
        if (stat.del_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_UP;
        end else begin
          cmd.dec_cnt = 1'b1;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WR_RDATA;
        cmd.ptr_inc = 1'b1;
      end
      S_IDX_CHK: begin
        cmd.res_load       = 1'b1;
        cmd.res_status     = ST_OK;
        cmd.res_pos_sel    = POS_IDX;
        cmd.res_kout_rdata = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/skt_dp.sv]
`default_nettype none

module skt_dp #(
  parameter int unsigned CAPACITY = skt_pkg::SKT_CAPACITY
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [skt_pkg::OP_W-1:0]         opcode,
  input  logic signed [skt_pkg::KEY_W-1:0] key_in,
  input  logic [skt_pkg::IDX_W-1:0]        index_in,
  input  skt_pkg::skt_cmd_t                cmd,
  output skt_pkg::skt_stat_t               stat,
  output logic [skt_pkg::ST_W-1:0]         status,
  output logic [skt_pkg::POS_W-1:0]        position,
  output logic signed [skt_pkg::KEY_W-1:0] key_out,
  output logic [skt_pkg::CNT_W-1:0]        count
);
  import skt_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;

  // request and search registers
  op_t                    op_r;
  logic signed [KEY_W-1:0] key_r;
  logic [IDX_W-1:0]       idx_r;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          lo_r;
  logic [CW-1:0]          hix_r;   // exclusive upper bound
  logic [AW-1:0]          mid_r;
  logic [CW-1:0]          ptr_r;

  // result and output registers
  status_t                res_status_r;
  logic [POS_W-1:0]       res_pos_r;
  logic signed [KEY_W-1:0] res_kout_r;
  status_t                out_status_r;
  logic [POS_W-1:0]       out_pos_r;
  logic signed [KEY_W-1:0] out_kout_r;
  logic [CNT_W-1:0]       out_count_r;

  logic [CW:0]            mid_sum;
  logic [CW-1:0]          mid_nxt;
  logic [CW-1:0]          ptr_dn;
  logic [CW:0]            ptr_up;
  logic [AW-1:0]          raddr;
  logic [AW-1:0]          waddr;
  logic [KEY_W-1:0]       wdata;
  logic [KEY_W-1:0]       rd_data;
  logic [POS_W-1:0]       pos_nxt;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hix_r} - (CW+1)'(1);
  assign mid_nxt = mid_sum[CW:1];
  assign ptr_dn  = ptr_r - CW'(1);
  assign ptr_up  = {1'b0, ptr_r} + (CW+1)'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_MID:    raddr = mid_nxt[AW-1:0];
      RD_PTR_DN: raddr = ptr_dn[AW-1:0];
      RD_PTR_UP: raddr = ptr_up[AW-1:0];
      RD_IDX:    raddr = AW'(idx_r);
      default:   raddr = mid_nxt[AW-1:0];
    endcase
  end

  assign waddr = ptr_r[AW-1:0];
  assign wdata = (cmd.wr_src == WR_KEY) ? key_r : rd_data;

  skt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_skt_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_comb begin
    stat           = '0;
    stat.op        = op_r;
    stat.full      = (count_r == CW'(CAPACITY));
    stat.idx_ok    = (XW'(idx_r) < XW'(count_r));
    stat.range_ok  = (lo_r < hix_r);
    stat.rd_eq_key = ($signed(rd_data) == key_r);
    stat.rd_lt_key = ($signed(rd_data) < key_r);
    stat.rd_gt_key = ($signed(rd_data) > key_r);
    stat.at_bottom = (ptr_r == '0);
    stat.del_more  = (ptr_up < {1'b0, count_r});
  end

  always_comb begin
    case (cmd.res_pos_sel)
      POS_ZERO: pos_nxt = '0;
      POS_MID:  pos_nxt = POS_W'(mid_r);
      POS_PTR:  pos_nxt = POS_W'(ptr_r);
      POS_IDX:  pos_nxt = idx_r;
      default:  pos_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear_cnt) begin
      count_r <= '0;
    end else if (cmd.inc_cnt) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.dec_cnt) begin
      count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r  <= op_t'(opcode);
      key_r <= key_in;
      idx_r <= index_in;
      lo_r  <= '0;
      hix_r <= count_r;
    end else if (cmd.lo_up) begin
      lo_r <= CW'(mid_r) + CW'(1);
    end else if (cmd.hi_down) begin
      hix_r <= CW'(mid_r);
    end

    if (cmd.mid_load) begin
      mid_r <= mid_nxt[AW-1:0];
    end

    if (cmd.ptr_from_cnt) begin
      ptr_r <= count_r;
    end else if (cmd.ptr_from_mid) begin
      ptr_r <= CW'(mid_r);
    end else if (cmd.ptr_dec) begin
      ptr_r <= ptr_dn;
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_up[CW-1:0];
    end

    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_pos_r    <= pos_nxt;
      res_kout_r   <= cmd.res_kout_rdata ? $signed(rd_data) : '0;
    end

    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_pos_r    <= res_pos_r;
      out_kout_r   <= res_kout_r;
      out_count_r  <= CNT_W'(count_r);
    end
  end

  assign status   = out_status_r;
  assign position = out_pos_r;
  assign key_out  = out_kout_r;
  assign count    = out_count_r;

endmodule

`default_nettype wire

[hw/rtl/sorted_key_table.sv]
// sorted_key_table: a table of signed 32-bit keys held in ascending order.
// Channels: in_chan carries one request per transaction (opcode, key_in,
// index_in); out_chan returns exactly one result transaction per request
// (status, position, key_out, count). Both use valid/ready; a transaction
// moves on a rising edge with valid and ready high.
// Requests are served one at a time. A result sits in an output register,
// so the next request is taken while the previous result waits; a stalled
// receiver only blocks the block once a second result is finished.
// Steps per request, from accept to result valid (the key RAM has a single
// read port with registered data):
//   clear, bad index, full, unused opcode: result set at dispatch
//   read at index: one RAM read; search, duplicate on unique insert: one
//     RAM read per probe (at most floor(log2(count))+1 probes)
//   insert: a read and write per key shifted up, then the key is written;
//     a unique insert first runs the search lookup
//   delete: search probes, then a read and write per key shifted down
// The block returns to idle before the next request is taken.
// Reset clears the entry count and the output valid; the key RAM is not
// cleared, since only entries below the count are ever read.
`default_nettype none

module sorted_key_table #(
  parameter int unsigned CAPACITY = skt_pkg::SKT_CAPACITY
) (
  input logic         clk,
  input logic         rst_n,
  skt_req_if.sink     in_chan,
  skt_rsp_if.source   out_chan
);
  import skt_pkg::*;

  skt_cmd_t  cmd;
  skt_stat_t stat;

  // sequencer: walks search probes and shift steps
  skt_ctrl u_skt_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // key RAM, search bounds, shift pointer, count and output register
  skt_dp #(
    .CAPACITY (CAPACITY)
  ) u_skt_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .opcode   (in_chan.opcode),
    .key_in   (in_chan.key_in),
    .index_in (in_chan.index_in),
    .cmd      (cmd),
    .stat     (stat),
    .status   (out_chan.status),
    .position (out_chan.position),
    .key_out  (out_chan.key_out),
    .count    (out_chan.count)
  );

endmodule

`default_nettype wire

[hw/rtl/skt_checker.sv]
`default_nettype none

module skt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [skt_pkg::ST_W-1:0]         status,
  input logic [skt_pkg::POS_W-1:0]        position,
  input logic signed [skt_pkg::KEY_W-1:0] key_out
);
  import skt_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position)
                                && $stable(key_out))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // a failed request returns no key
  a_kout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |-> key_out == '0)
    else $error("key returned on a failed request");

  // failures other than duplicate report position zero
  a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_FULL || status == ST_MISSING || status == ST_BADIDX)
    |-> position == '0)
    else $error("nonzero position on a failed request");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .status    (out_chan.status),
  .position  (out_chan.position),
  .key_out   (out_chan.key_out)
);

`default_nettype wire

[test/tb_sorted_key_table.sv]
`default_nettype none

module tb_sorted_key_table;
  import skt_pkg::*;

  // Opcodes six and seven are not decoded by the block; they must pass through untouched.
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;
  localparam logic [KEY_W-1:0] KEY_M5  = 32'hffff_fffb;

  localparam int DIR_ROWS     = 24;
  localparam int RANDOM_REQS  = 800;
  localparam int HOLD_CYCLES  = 400;   // receiver back-pressure stretch
  localparam int STALL_LIMIT  = 3000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES = 200;   // worst request is a full-table shift

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] key_out;
    logic [CNT_W-1:0] count;
  } table_result_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
    logic             typed;  // take want as written instead of the predictor's answer
    table_result_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  skt_req_if req_chan ();
  skt_rsp_if rsp_chan ();

  sorted_key_table i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (rsp_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the table: keys in ascending signed order plus the fill level.
  logic signed [KEY_W-1:0] shadow_keys [SKT_CAPACITY];
  int                      shadow_count;

  table_result_t result_q [$];  // expected results, oldest first

  int  errors;
  int  sent;
  int  checked;
  int  full_seen, dup_seen, missing_seen, badidx_seen;
  int  peak_count;
  bit  calm;      // no idling on either side while set
  bit  hold_req;  // ask the receiver for one long hold-off

  // Binary search with floor midpoint; return the index hit, or -1.
  function automatic int probe_key(logic signed [KEY_W-1:0] k);
    int lo, hi, mid;
    lo = 0;
    hi = shadow_count - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (shadow_keys[mid] == k) return mid;
      if (shadow_keys[mid] < k) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  // Insert after any equal keys, shifting larger keys up by one.
  function automatic int place_key(logic signed [KEY_W-1:0] k);
    int pos;
    pos = shadow_count;
    while (pos > 0 && shadow_keys[pos-1] > k) begin
      shadow_keys[pos] = shadow_keys[pos-1];
      pos--;
    end
    shadow_keys[pos] = k;
    shadow_count++;
    return pos;
  endfunction

  // Apply one request to the shadow table and return the result it must produce.
  function automatic table_result_t predict_request(logic [OP_W-1:0] op,
                                                    logic signed [KEY_W-1:0] k,
                                                    logic [IDX_W-1:0] idx);
    table_result_t r;
    int            hit;
    int            j;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_CLEAR: shadow_count = 0;
      OP_INS_DUP: begin
        if (shadow_count >= SKT_CAPACITY) r.status = ST_FULL;
        else r.position = POS_W'(place_key(k));
      end
      OP_INS_UNI: begin
        // full check wins over the duplicate check
        if (shadow_count >= SKT_CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          hit = probe_key(k);
          if (hit >= 0) begin
            r.status   = ST_DUP;
            r.position = POS_W'(hit);
          end else begin
            r.position = POS_W'(place_key(k));
          end
        end
      end
      OP_DELETE: begin
        hit = probe_key(k);
        if (hit < 0) begin
          r.status = ST_MISSING;
        end else begin
          r.position = POS_W'(hit);
          for (j = hit; j + 1 < shadow_count; j++) shadow_keys[j] = shadow_keys[j+1];
          shadow_count--;
        end
      end
      OP_SEARCH: begin
        hit = probe_key(k);
        if (hit < 0) r.status = ST_MISSING;
        else r.position = POS_W'(hit);
      end
      OP_READ: begin
        if (int'(idx) < shadow_count) begin
          r.position = idx;
          r.key_out  = shadow_keys[idx];
        end else begin
          r.status = ST_BADIDX;
        end
      end
      default: ;  // spare opcodes leave the table alone
    endcase
    r.count = CNT_W'(shadow_count);
    return r;
  endfunction

  // Mix keys already held (hits), a narrow band around zero (duplicates),
  // the extremes and fully random words.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 40 && shadow_count > 0) return shadow_keys[$urandom_range(shadow_count - 1)];
    if (r < 45) return KEY_MIN;
    if (r < 50) return KEY_MAX;
    if (r < 75) return 32'($urandom_range(16)) - 32'd8;
    return $urandom;
  endfunction

  // Mostly legal read positions, now and then any position.
  function automatic logic [IDX_W-1:0] pick_index();
    if (shadow_count > 0 && $urandom_range(3) != 0)
      return IDX_W'($urandom_range(shadow_count - 1));
    return IDX_W'($urandom_range(63));
  endfunction

  // Offer one request, hold it until the transaction completes, then predict.
  task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                              logic [IDX_W-1:0] idx, logic typed, table_result_t want);
    table_result_t pred;
    while (!calm && $urandom_range(99) < 33) begin
      req_chan.valid <= 1'b0;
      @(posedge clk);
    end
    req_chan.valid    <= 1'b1;
    req_chan.opcode   <= op;
    req_chan.key_in   <= k;
    req_chan.index_in <= idx;
    @(posedge clk);
    while (!req_chan.ready) @(posedge clk);
    pred = predict_request(op, k, idx);
    result_q.push_back(typed ? want : pred);
    sent++;
    if (shadow_count > peak_count) peak_count = shadow_count;
  endtask

  // Grow the table to capacity, then poke at the full table from every side.
  task automatic fill_table();
    int tries;
    tries = 0;
    while (shadow_count < SKT_CAPACITY && tries < 300) begin
      send_request($urandom_range(1) ? OP_INS_DUP : OP_INS_UNI, pick_key(),
                   IDX_W'($urandom_range(63)), 1'b0, '0);
      tries++;
    end
    send_request(OP_INS_DUP, pick_key(), 6'd0, 1'b0, '0);
    send_request(OP_INS_UNI, $urandom, 6'd0, 1'b0, '0);
    send_request(OP_READ, pick_key(), 6'd63, 1'b0, '0);
    send_request(OP_SEARCH, pick_key(), 6'd0, 1'b0, '0);
    send_request(OP_DELETE, shadow_keys[0], 6'd0, 1'b0, '0);
    send_request(OP_INS_UNI, KEY_MIN, 6'd0, 1'b0, '0);
    send_request(OP_INS_DUP, KEY_MAX, 6'd0, 1'b0, '0);
  endtask

  // A run of mixed requests with random content.
  task automatic random_burst(int n);
    int               r;
    int               i;
    logic [OP_W-1:0]  op;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 2)       op = OP_CLEAR;
      else if (r < 5)  op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
      else if (r < 25) op = OP_INS_DUP;
      else if (r < 45) op = OP_INS_UNI;
      else if (r < 65) op = OP_DELETE;
      else if (r < 82) op = OP_SEARCH;
      else             op = OP_READ;
      send_request(op, pick_key(), pick_index(), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    stim_row_t dir_rows [DIR_ROWS];
    bit        hold_done;
    bit        refill_done;
    int        i;

    // Directed rows: empty-table errors, spare opcodes, extremes, duplicate
    // handling, insert ahead of the first entry, reads on both sides of the
    // count, and clear.
    dir_rows = '{
      '{OP_READ,    32'd0,   6'd0,  1'b1, '{ST_BADIDX,  6'd0, 32'd0,   7'd0}},
      '{OP_SEARCH,  32'd0,   6'd0,  1'b1, '{ST_MISSING, 6'd0, 32'd0,   7'd0}},
      '{OP_DELETE,  32'd7,   6'd0,  1'b1, '{ST_MISSING, 6'd0, 32'd0,   7'd0}},
      '{OP_SPARE6,  KEY_M5,  6'd63, 1'b1, '{ST_OK,      6'd0, 32'd0,   7'd0}},
      '{OP_SPARE7,  KEY_MAX, 6'd0,  1'b1, '{ST_OK,      6'd0, 32'd0,   7'd0}},
      '{OP_INS_DUP, KEY_MIN, 6'd0,  1'b1, '{ST_OK,      6'd0, 32'd0,   7'd1}},
      '{OP_INS_DUP, KEY_MAX, 6'd0,  1'b1, '{ST_OK,      6'd1, 32'd0,   7'd2}},
      '{OP_INS_UNI, 32'd0,   6'd0,  1'b1, '{ST_OK,      6'd1, 32'd0,   7'd3}},
      '{OP_INS_UNI, 32'd0,   6'd0,  1'b1, '{ST_DUP,     6'd1, 32'd0,   7'd3}},
      '{OP_INS_DUP, 32'd0,   6'd0,  1'b1, '{ST_OK,      6'd2, 32'd0,   7'd4}},
      '{OP_DELETE,  KEY_MIN, 6'd0,  1'b1, '{ST_OK,      6'd0, 32'd0,   7'd3}},
      '{OP_INS_UNI, KEY_M5,  6'd0,  1'b1, '{ST_OK,      6'd0, 32'd0,   7'd4}},
      '{OP_READ,    32'd0,   6'd0,  1'b1, '{ST_OK,      6'd0, KEY_M5,  7'd4}},
      '{OP_READ,    32'd0,   6'd3,  1'b1, '{ST_OK,      6'd3, KEY_MAX, 7'd4}},
      '{OP_READ,    32'd0,   6'd4,  1'b1, '{ST_BADIDX,  6'd0, 32'd0,   7'd4}},
      '{OP_READ,    32'd0,   6'd63, 1'b1, '{ST_BADIDX,  6'd0, 32'd0,   7'd4}},
      '{OP_SEARCH,  32'd0,   6'd0,  1'b0, '0},
      '{OP_SEARCH,  KEY_MIN, 6'd0,  1'b1, '{ST_MISSING, 6'd0, 32'd0,   7'd4}},
      '{OP_DELETE,  KEY_MAX, 6'd0,  1'b1, '{ST_OK,      6'd3, 32'd0,   7'd3}},
      '{OP_INS_DUP, 32'd1,   6'd0,  1'b0, '0},
      '{OP_SEARCH,  KEY_M5,  6'd0,  1'b0, '0},
      '{OP_CLEAR,   KEY_MAX, 6'd63, 1'b1, '{ST_OK,      6'd0, 32'd0,   7'd0}},
      '{OP_READ,    32'd0,   6'd0,  1'b1, '{ST_BADIDX,  6'd0, 32'd0,   7'd0}},
      '{OP_DELETE,  KEY_M5,  6'd0,  1'b1, '{ST_MISSING, 6'd0, 32'd0,   7'd0}}
    };

    hold_done   = 1'b0;
    refill_done = 1'b0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    shadow_count = 0;

    // Hold reset with the request channel quiet.
    rst_n             <= 1'b0;
    req_chan.valid    <= 1'b0;
    req_chan.opcode   <= OP_CLEAR;
    req_chan.key_in   <= '0;
    req_chan.index_in <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++)
      send_request(dir_rows[i].op, dir_rows[i].key, dir_rows[i].idx,
                   dir_rows[i].typed, dir_rows[i].want);

    // Start random traffic with a full table so the capacity cases come early.
    fill_table();
    while (sent < DIR_ROWS + RANDOM_REQS) begin
      // Stall the receiver once while requests keep coming.
      if (!hold_done && sent >= 250) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      // Run back to back for a stretch.
      calm = (sent >= 380 && sent < 520);
      if (!refill_done && sent >= 600) begin
        send_request(OP_CLEAR, $urandom, IDX_W'($urandom_range(63)), 1'b0, '0);
        fill_table();
        refill_done = 1'b1;
      end else begin
        random_burst($urandom_range(40, 10));
      end
    end
    req_chan.valid <= 1'b0;

    // Drain: wait for every expected result, then watch for stray ones.
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests, %0d results checked; peak fill %0d of %0d", sent, checked,
             peak_count, SKT_CAPACITY);
    $display("error results seen: full %0d, duplicate %0d, not found %0d, bad index %0d",
             full_seen, dup_seen, missing_seen, badidx_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: random ready, one long hold-off on request, none while calm.
  initial begin : receiver
    rsp_chan.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_chan.ready <= calm || ($urandom_range(99) >= 33);
        @(posedge clk);
      end
    end
  end

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk) begin : check_results
    table_result_t want;
    if (rst_n && rsp_chan.valid && rsp_chan.ready) begin
      if (result_q.size() == 0) begin
        $error("result with no request outstanding: status %0d position %0d count %0d",
               rsp_chan.status, rsp_chan.position, rsp_chan.count);
        errors++;
      end else begin
        want = result_q.pop_front();
        checked++;
        if (rsp_chan.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
          errors++;
        end
        if (rsp_chan.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, rsp_chan.position);
          errors++;
        end
        if (rsp_chan.key_out !== want.key_out) begin
          $error("key_out: expected %0d, got %0d", $signed(want.key_out), rsp_chan.key_out);
          errors++;
        end
        if (rsp_chan.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, rsp_chan.count);
          errors++;
        end
        case (want.status)
          ST_FULL:    full_seen++;
          ST_DUP:     dup_seen++;
          ST_MISSING: missing_seen++;
          ST_BADIDX:  badidx_seen++;
          default: ;
        endcase
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n) begin
      quiet = 0;
    end else if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

[sorted_key_table.f]
hw/rtl/skt_pkg.sv
hw/rtl/skt_if.sv
hw/rtl/skt_ram.sv
hw/rtl/skt_ctrl.sv
hw/rtl/skt_dp.sv
hw/rtl/sorted_key_table.sv
hw/rtl/skt_checker.sv
test/tb_sorted_key_table.sv
